// ----- rtl/rje_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rje_pkg
// Shared types, constants and fixed-point helpers for the reprojection
// residual and Jacobian engine.
// ----------------------------------------------------------------------------
package rje_pkg;

   localparam int DATA_W         = 32;
   localparam int FRAC_BITS      = 16;
   localparam int POSE_SLOTS     = 64;
   localparam int WORDS_PER_POSE = 12;
   localparam int SLOT_AW        = (POSE_SLOTS > 1) ? $clog2(POSE_SLOTS) : 1;
   localparam int ADDR_W         = 5;

   // products are 64 bit, sums are handled at 66 bit before saturation
   localparam int PROD_W  = 2 * DATA_W;
   localparam int WIDE_W  = PROD_W + 2;

   // divider: 65 bit signed numerator, 32 quotient bits, one per stage
   localparam int DIV_NUM_W = PROD_W + 1;
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_LAT   = DIV_STEPS + 2;

   localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(64'sd2147483647);
   localparam logic signed [WIDE_W-1:0] SAT_MIN = -(WIDE_W'(64'sd2147483648));
   localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh8000_0000;

   typedef enum logic [0:0] {
      OP_LOAD    = 1'b0,
      OP_OBSERVE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      REG_FOCAL_X  = 3'd0,
      REG_FOCAL_Y  = 3'd1,
      REG_SKEW     = 3'd2,
      REG_CENTER_X = 3'd3,
      REG_CENTER_Y = 3'd4
   } reg_index_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [5:0]         pose_slot;
      logic [3:0]         pose_element;
      logic signed [31:0] pose_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] seen_u;
      logic signed [31:0] seen_v;
   } req_type;

   typedef struct packed {
      logic signed [31:0] residual;
      logic signed [31:0] pose_jac_0;
      logic signed [31:0] pose_jac_1;
      logic signed [31:0] pose_jac_2;
      logic signed [31:0] pose_jac_3;
      logic signed [31:0] pose_jac_4;
      logic signed [31:0] pose_jac_5;
      logic signed [31:0] point_jac_0;
      logic signed [31:0] point_jac_1;
      logic signed [31:0] point_jac_2;
      logic               depth_bad;
      logic               last;
   } rsp_type;

   // sideband carried alongside the first divider round
   typedef struct packed {
      logic                   depth_bad;
      logic [DATA_W-1:0]      z;
      logic [2:0][DATA_W-1:0] w;
      logic [8:0][DATA_W-1:0] rot;
      logic [DATA_W-1:0]      seen_u;
      logic [DATA_W-1:0]      seen_v;
   } sb1_type;

   // sideband carried alongside the second divider round
   typedef struct packed {
      sb1_type           base;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] e;
      logic [DATA_W-1:0] qu;
      logic [DATA_W-1:0] qv;
   } sb2_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > SAT_MAX) begin
         r = Q_MAX;
      end else if (x < SAT_MIN) begin
         r = Q_MIN;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   // product shifted down by FRAC_BITS, rounding toward minus infinity
   function automatic logic signed [WIDE_W-1:0] fsh(input logic signed [PROD_W-1:0] p);
      logic signed [WIDE_W-1:0] x;
      x = WIDE_W'(p);
      return x >>> FRAC_BITS;
   endfunction

endpackage

// ----- rtl/rje_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rje_div
// Pipelined restoring divider, one quotient bit per stage. Signed numerator,
// positive divisor, quotient truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module rje_div (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic signed [rje_pkg::DIV_NUM_W-1:0]  num,
   input  logic [rje_pkg::DATA_W-1:0]            den,
   output logic signed [rje_pkg::DATA_W-1:0]     quo
);

   localparam int NW    = rje_pkg::DIV_NUM_W;
   localparam int DW    = rje_pkg::DATA_W;
   localparam int STEPS = rje_pkg::DIV_STEPS;

   logic [NW-1:0]    mag;
   logic [NW-DW-1:0] high;

   logic          neg_ff [STEPS+1];
   logic          ovf_ff [STEPS+1];
   logic [DW-1:0] rem_ff [STEPS+1];
   logic [DW-1:0] low_ff [STEPS+1];
   logic [DW-1:0] q_ff   [STEPS+1];
   logic [DW-1:0] den_ff [STEPS+1];

   logic signed [DW-1:0] quo_in;
   logic signed [DW-1:0] quo_ff;

   assign mag  = num[NW-1] ? NW'(-num) : NW'(num);
   assign high = mag[NW-1:DW];

   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff[0] <= num[NW-1];
         ovf_ff[0] <= high >= (NW-DW)'(den);
         rem_ff[0] <= high[DW-1:0];
         low_ff[0] <= mag[DW-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [DW:0] trial;
      logic        fit;

      assign trial = {rem_ff[k], low_ff[k][DW-1]};
      assign fit   = trial >= {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= fit ? DW'(trial - {1'b0, den_ff[k]}) : trial[DW-1:0];
            q_ff[k+1]   <= {q_ff[k][DW-2:0], fit};
            low_ff[k+1] <= {low_ff[k][DW-2:0], 1'b0};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   always_comb begin
      if (ovf_ff[STEPS]) begin
         quo_in = neg_ff[STEPS] ? rje_pkg::Q_MIN : rje_pkg::Q_MAX;
      end else if (neg_ff[STEPS]) begin
         quo_in = (q_ff[STEPS] > {1'b1, {(DW-1){1'b0}}}) ? rje_pkg::Q_MIN
                                                          : DW'(-q_ff[STEPS]);
      end else begin
         quo_in = q_ff[STEPS][DW-1] ? rje_pkg::Q_MAX : q_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

// ----- rtl/reprojection_jacobian_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reprojection_jacobian_engine_core
// Pinhole reprojection residual with pose and landmark Jacobians, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//  - Intrinsics sit in five APB registers (focal_x, focal_y, axis_skew,
//    center_x, center_y at byte offsets 0..16). Write them while idle.
//  - req channel: a load beat (opcode 0) writes one word of a 12-word pose
//    slot (R row-major, then t) and yields nothing. An observe beat (opcode 1)
//    yields two rsp beats, x row (last 0) then y row (last 1).
//  - A load is visible to an observe beat in the very next cycle.
//  - Path: req accept reaches the x row through two divider pipes of 34
//    stages each (quotients by depth, then the c/g terms); the y row
//    follows once the x row has been taken.
//  - Throughput: the pipeline takes one beat per cycle while req_stall is
//    low; the single rsp channel drains two rows per observation, so the
//    input is held while an x row waits to leave, loads included.
//  - Stall: the whole pipeline advances on one enable. When the output stage
//    holds an x row or a stalled y row, req_stall rises and nothing moves.
//  - Reset clears the valid bits and restores register defaults; the pose
//    table is not cleared, every slot must be loaded before use.
//  - Non-positive depth gives both rows with depth_bad set and all zeros.
// ----------------------------------------------------------------------------
module reprojection_jacobian_engine_core (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  rje_pkg::req_type               req_data,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rje_pkg::rsp_type               rsp_data,

   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rje_pkg::ADDR_W-1:0]     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam int DW  = rje_pkg::DATA_W;
   localparam int PW  = rje_pkg::PROD_W;
   localparam int WW  = rje_pkg::WIDE_W;
   localparam int NW  = rje_pkg::DIV_NUM_W;
   localparam int FB  = rje_pkg::FRAC_BITS;
   localparam int LAT = rje_pkg::DIV_LAT;
   localparam int WPP = rje_pkg::WORDS_PER_POSE;

   // ---------------- configuration registers ----------------
   logic [30:0]          focal_x_ff, focal_y_ff;
   logic signed [DW-1:0] skew_ff, center_x_ff, center_y_ff;
   logic                 cfg_wr;
   rje_pkg::reg_index_type cfg_idx;

   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = rje_pkg::reg_index_type'(paddr[4:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 31'd32768000;
         focal_y_ff  <= 31'd32768000;
         skew_ff     <= '0;
         center_x_ff <= 32'sd20971520;
         center_y_ff <= 32'sd15728640;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            rje_pkg::REG_FOCAL_X:  focal_x_ff  <= pwdata[30:0];
            rje_pkg::REG_FOCAL_Y:  focal_y_ff  <= pwdata[30:0];
            rje_pkg::REG_SKEW:     skew_ff     <= pwdata;
            rje_pkg::REG_CENTER_X: center_x_ff <= pwdata;
            rje_pkg::REG_CENTER_Y: center_y_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         rje_pkg::REG_FOCAL_X:  prdata = {1'b0, focal_x_ff};
         rje_pkg::REG_FOCAL_Y:  prdata = {1'b0, focal_y_ff};
         rje_pkg::REG_SKEW:     prdata = skew_ff;
         rje_pkg::REG_CENTER_X: prdata = center_x_ff;
         rje_pkg::REG_CENTER_Y: prdata = center_y_ff;
         default:               prdata = '0;
      endcase
   end

   // ---------------- pipeline enable ----------------
   logic adv;
   logic v8_ff, row8_ff;
   logic accept;

   assign adv       = !v8_ff || (row8_ff && !rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   // ---------------- pose table ----------------
   logic [DW-1:0] pose_mem [rje_pkg::POSE_SLOTS][WPP];
   logic          slot_ok;
   logic [rje_pkg::SLOT_AW-1:0] slot_idx;

   assign slot_ok  = 32'(req_data.pose_slot) < rje_pkg::POSE_SLOTS;
   assign slot_idx = rje_pkg::SLOT_AW'(req_data.pose_slot);

   always_ff @(posedge clock) begin
      if (accept && req_data.opcode == rje_pkg::OP_LOAD && slot_ok &&
          32'(req_data.pose_element) < WPP) begin
         pose_mem[slot_idx][req_data.pose_element] <= req_data.pose_value;
      end
   end

   // ---------------- stage 1: capture, table read ----------------
   logic                 v1_ff, ok1_ff;
   logic [DW-1:0]        rd1_ff [WPP];
   logic signed [DW-1:0] pt1_ff [3];
   logic [DW-1:0]        su1_ff, sv1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid && req_data.opcode == rje_pkg::OP_OBSERVE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd1_ff    <= pose_mem[slot_idx];
         ok1_ff    <= slot_ok;
         pt1_ff[0] <= req_data.point_x;
         pt1_ff[1] <= req_data.point_y;
         pt1_ff[2] <= req_data.point_z;
         su1_ff    <= req_data.seen_u;
         sv1_ff    <= req_data.seen_v;
      end
   end

   // ---------------- stage 2: R*P products ----------------
   logic                 v2_ff;
   logic signed [DW-1:0] rot1 [9];
   logic signed [DW-1:0] tr1  [3];
   logic signed [DW-1:0] rot2_ff [9];
   logic signed [DW-1:0] tr2_ff  [3];
   logic signed [PW-1:0] prod2_ff [9];
   logic [DW-1:0]        su2_ff, sv2_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         rot1[i] = ok1_ff ? rd1_ff[i] : '0;
      end
      for (int i = 0; i < 3; i++) begin
         tr1[i] = ok1_ff ? rd1_ff[9+i] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 9; i++) begin
            rot2_ff[i]  <= rot1[i];
            prod2_ff[i] <= rot1[i] * pt1_ff[i%3];
         end
         tr2_ff <= tr1;
         su2_ff <= su1_ff;
         sv2_ff <= sv1_ff;
      end
   end

   // ---------------- stage 3: w and camera point ----------------
   logic                 v3_ff;
   logic signed [WW-1:0] acc2 [3];
   logic signed [DW-1:0] w3_ff [3];
   logic signed [DW-1:0] cam3_ff [3];
   logic signed [DW-1:0] rot3_ff [9];
   logic [DW-1:0]        su3_ff, sv3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc2[i] = rje_pkg::fsh(prod2_ff[3*i]) + rje_pkg::fsh(prod2_ff[3*i+1])
                 + rje_pkg::fsh(prod2_ff[3*i+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            w3_ff[i]   <= rje_pkg::sat32(acc2[i]);
            cam3_ff[i] <= rje_pkg::sat32(acc2[i] + WW'(tr2_ff[i]));
         end
         rot3_ff <= rot2_ff;
         su3_ff  <= su2_ff;
         sv3_ff  <= sv2_ff;
      end
   end

   // ---------------- stage 4: numerator products ----------------
   logic                 v4_ff, bad4_ff;
   logic signed [DW-1:0] z4_ff;
   logic signed [PW-1:0] fxx4_ff, sy4_ff, fyy4_ff;
   logic signed [DW-1:0] w4_ff [3];
   logic signed [DW-1:0] rot4_ff [9];
   logic [DW-1:0]        su4_ff, sv4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad4_ff <= cam3_ff[2] <= 0;
         z4_ff   <= cam3_ff[2];
         fxx4_ff <= $signed({1'b0, focal_x_ff}) * cam3_ff[0];
         sy4_ff  <= skew_ff * cam3_ff[1];
         fyy4_ff <= $signed({1'b0, focal_y_ff}) * cam3_ff[1];
         w4_ff   <= w3_ff;
         rot4_ff <= rot3_ff;
         su4_ff  <= su3_ff;
         sv4_ff  <= sv3_ff;
      end
   end

   // ---------------- stage 5: divider operands ----------------
   logic                 v5_ff;
   logic signed [NW-1:0] nu5_ff, nv5_ff, na5_ff, nb5_ff, ne5_ff;
   rje_pkg::sb1_type     sb5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nu5_ff <= NW'(fxx4_ff) + NW'(sy4_ff);
         nv5_ff <= NW'(fyy4_ff);
         na5_ff <= NW'($signed({1'b0, focal_x_ff})) <<< FB;
         nb5_ff <= NW'(skew_ff) <<< FB;
         ne5_ff <= NW'($signed({1'b0, focal_y_ff})) <<< FB;
         sb5_ff.depth_bad <= bad4_ff;
         sb5_ff.z         <= z4_ff;
         for (int i = 0; i < 3; i++) begin
            sb5_ff.w[i] <= w4_ff[i];
         end
         for (int i = 0; i < 9; i++) begin
            sb5_ff.rot[i] <= rot4_ff[i];
         end
         sb5_ff.seen_u <= su4_ff;
         sb5_ff.seen_v <= sv4_ff;
      end
   end

   // ---------------- divider round 1: qu, qv, a, b, e ----------------
   logic signed [DW-1:0] qu_q, qv_q, a_q, b_q, e_q;

   rje_div u_div_qu (.clock(clock), .enable(adv), .num(nu5_ff), .den(sb5_ff.z), .quo(qu_q));
   rje_div u_div_qv (.clock(clock), .enable(adv), .num(nv5_ff), .den(sb5_ff.z), .quo(qv_q));
   rje_div u_div_a  (.clock(clock), .enable(adv), .num(na5_ff), .den(sb5_ff.z), .quo(a_q));
   rje_div u_div_b  (.clock(clock), .enable(adv), .num(nb5_ff), .den(sb5_ff.z), .quo(b_q));
   rje_div u_div_e  (.clock(clock), .enable(adv), .num(ne5_ff), .den(sb5_ff.z), .quo(e_q));

   logic [LAT-1:0]   vl1_ff;
   rje_pkg::sb1_type sl1_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vl1_ff <= '0;
      end else if (adv) begin
         vl1_ff <= {vl1_ff[LAT-2:0], v5_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sl1_ff[0] <= sb5_ff;
         for (int i = 1; i < LAT; i++) begin
            sl1_ff[i] <= sl1_ff[i-1];
         end
      end
   end

   // ---------------- divider round 2: c, g (numerator negated) ----------------
   logic signed [NW-1:0] nc, ng;
   logic signed [DW-1:0] c_q, g_q;
   rje_pkg::sb2_type     sb6;

   assign nc = -(NW'(qu_q) <<< FB);
   assign ng = -(NW'(qv_q) <<< FB);

   rje_div u_div_c (.clock(clock), .enable(adv), .num(nc), .den(sl1_ff[LAT-1].z), .quo(c_q));
   rje_div u_div_g (.clock(clock), .enable(adv), .num(ng), .den(sl1_ff[LAT-1].z), .quo(g_q));

   always_comb begin
      sb6.base = sl1_ff[LAT-1];
      sb6.a    = a_q;
      sb6.b    = b_q;
      sb6.e    = e_q;
      sb6.qu   = qu_q;
      sb6.qv   = qv_q;
   end

   logic [LAT-1:0]   vl2_ff;
   rje_pkg::sb2_type sl2_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vl2_ff <= '0;
      end else if (adv) begin
         vl2_ff <= {vl2_ff[LAT-2:0], vl1_ff[LAT-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sl2_ff[0] <= sb6;
         for (int i = 1; i < LAT; i++) begin
            sl2_ff[i] <= sl2_ff[i-1];
         end
      end
   end

   // ---------------- stage 7: Jacobian products, residuals ----------------
   rje_pkg::sb2_type     s2;
   logic signed [DW-1:0] a6, b6, e6, w6 [3], r6 [9];
   logic signed [DW-1:0] u6, v6;

   logic                 v7_ff, bad7_ff;
   logic signed [DW-1:0] a7_ff, b7_ff, c7_ff, e7_ff, g7_ff;
   logic signed [DW-1:0] rx7_ff, ry7_ff;
   logic signed [PW-1:0] pcw1_ff, pbw2_ff, paw2_ff, pcw0_ff, pbw0_ff, paw1_ff;
   logic signed [PW-1:0] pgw1_ff, pew2_ff, pgw0_ff, pew0_ff;
   logic signed [PW-1:0] par_ff [3], pbr_ff [3], pcr_ff [3], per_ff [3], pgr_ff [3];

   assign s2 = sl2_ff[LAT-1];
   assign a6 = s2.a;
   assign b6 = s2.b;
   assign e6 = s2.e;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w6[i] = s2.base.w[i];
      end
      for (int i = 0; i < 9; i++) begin
         r6[i] = s2.base.rot[i];
      end
   end

   assign u6 = rje_pkg::sat32(WW'($signed(s2.qu)) + WW'(center_x_ff));
   assign v6 = rje_pkg::sat32(WW'($signed(s2.qv)) + WW'(center_y_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= vl2_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad7_ff <= s2.base.depth_bad;
         a7_ff   <= a6;
         b7_ff   <= b6;
         c7_ff   <= c_q;
         e7_ff   <= e6;
         g7_ff   <= g_q;
         rx7_ff  <= rje_pkg::sat32(WW'(u6) - WW'($signed(s2.base.seen_u)));
         ry7_ff  <= rje_pkg::sat32(WW'(v6) - WW'($signed(s2.base.seen_v)));
         pcw1_ff <= c_q * w6[1];
         pbw2_ff <= b6 * w6[2];
         paw2_ff <= a6 * w6[2];
         pcw0_ff <= c_q * w6[0];
         pbw0_ff <= b6 * w6[0];
         paw1_ff <= a6 * w6[1];
         pgw1_ff <= g_q * w6[1];
         pew2_ff <= e6 * w6[2];
         pgw0_ff <= g_q * w6[0];
         pew0_ff <= e6 * w6[0];
         for (int j = 0; j < 3; j++) begin
            par_ff[j] <= a6 * r6[j];
            pbr_ff[j] <= b6 * r6[3+j];
            pcr_ff[j] <= c_q * r6[6+j];
            per_ff[j] <= e6 * r6[3+j];
            pgr_ff[j] <= g_q * r6[6+j];
         end
      end
   end

   // ---------------- stage 8: sums, output rows ----------------
   rje_pkg::rsp_type rowx_in, rowy_in;
   rje_pkg::rsp_type rowx_ff, rowy_ff;
   logic signed [DW-1:0] ptx [3], pty [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ptx[j] = rje_pkg::sat32(rje_pkg::fsh(par_ff[j]) + rje_pkg::fsh(pbr_ff[j])
                                 + rje_pkg::fsh(pcr_ff[j]));
         pty[j] = rje_pkg::sat32(rje_pkg::fsh(per_ff[j]) + rje_pkg::fsh(pgr_ff[j]));
      end

      rowx_in = '0;
      rowy_in = '0;
      rowx_in.depth_bad = bad7_ff;
      rowy_in.depth_bad = bad7_ff;
      rowx_in.last      = 1'b0;
      rowy_in.last      = 1'b1;
      if (!bad7_ff) begin
         rowx_in.residual    = rx7_ff;
         rowx_in.pose_jac_0  = a7_ff;
         rowx_in.pose_jac_1  = b7_ff;
         rowx_in.pose_jac_2  = c7_ff;
         rowx_in.pose_jac_3  = rje_pkg::sat32(rje_pkg::fsh(pcw1_ff) - rje_pkg::fsh(pbw2_ff));
         rowx_in.pose_jac_4  = rje_pkg::sat32(rje_pkg::fsh(paw2_ff) - rje_pkg::fsh(pcw0_ff));
         rowx_in.pose_jac_5  = rje_pkg::sat32(rje_pkg::fsh(pbw0_ff) - rje_pkg::fsh(paw1_ff));
         rowx_in.point_jac_0 = ptx[0];
         rowx_in.point_jac_1 = ptx[1];
         rowx_in.point_jac_2 = ptx[2];

         rowy_in.residual    = ry7_ff;
         rowy_in.pose_jac_0  = '0;
         rowy_in.pose_jac_1  = e7_ff;
         rowy_in.pose_jac_2  = g7_ff;
         rowy_in.pose_jac_3  = rje_pkg::sat32(rje_pkg::fsh(pgw1_ff) - rje_pkg::fsh(pew2_ff));
         rowy_in.pose_jac_4  = rje_pkg::sat32(-rje_pkg::fsh(pgw0_ff));
         rowy_in.pose_jac_5  = rje_pkg::sat32(rje_pkg::fsh(pew0_ff));
         rowy_in.point_jac_0 = pty[0];
         rowy_in.point_jac_1 = pty[1];
         rowy_in.point_jac_2 = pty[2];
      end
   end

   // output holding stage: both rows land together, x row goes first
   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff   <= 1'b0;
         row8_ff <= 1'b0;
      end else if (adv) begin
         v8_ff   <= v7_ff;
         row8_ff <= 1'b0;
      end else if (!rsp_stall) begin
         row8_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rowx_ff <= rowx_in;
         rowy_ff <= rowy_in;
      end
   end

   assign rsp_valid = v8_ff;
   assign rsp_data  = row8_ff ? rowy_ff : rowx_ff;

   // ---------------- checks ----------------
   // x row delivered means the y row of the same observation is next
   ap_y_follows_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid && rsp_data.last)
      else $error("y row did not follow x row");

   // the input side is only held back by a row waiting at the output
   ap_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output stage");

   // a load beat never enters the compute pipe
   ap_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == rje_pkg::OP_LOAD |=> !v1_ff)
      else $error("load beat produced a pipeline entry");

   // bad depth rows carry no numbers
   ap_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.depth_bad |->
         rsp_data.residual == 0 && rsp_data.pose_jac_1 == 0 && rsp_data.point_jac_0 == 0)
      else $error("depth_bad row carries nonzero data");

   // stalled pipeline holds the output row index
   ap_row_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(row8_ff))
      else $error("row index moved under stall");

endmodule
